// ===== rtl/swtq_pkg.sv =====
// ----------------------------------------------------------------------------
// swtq_pkg
// Shared types, codes and constants of the sorted wakeup timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package swtq_pkg;

  localparam int WAKE_BITS          = 63;
  localparam int DUR_BITS           = 32;
  localparam int TID_PORT_BITS      = 8;
  localparam int MAX_REPORTS        = 16;
  localparam int REPORT_BITS        = $clog2(MAX_REPORTS);
  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int THREAD_ID_BITS_DEF = 8;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_SLEEP = 1'b1;

  localparam logic [1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [1:0] KIND_REFUSED  = 2'd1;
  localparam logic [1:0] KIND_WOKEN    = 2'd2;

  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;

  typedef struct packed {
    logic [1:0]           op;
    logic [WAKE_BITS-1:0] key_wt;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/swtq_cell.sv =====
// ----------------------------------------------------------------------------
// swtq_cell
// One slot of the sorted queue: holds, takes the key, or shifts from a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module swtq_cell
  import swtq_pkg::*;
#(
  parameter int TID_BITS = THREAD_ID_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cell_cmd_t            cmd,
  input  wire logic [TID_BITS-1:0]  key_thr,
  input  wire logic                 left_valid,
  input  wire logic [WAKE_BITS-1:0] left_wt,
  input  wire logic [TID_BITS-1:0]  left_thr,
  input  wire logic                 left_le,
  input  wire logic                 right_valid,
  input  wire logic [WAKE_BITS-1:0] right_wt,
  input  wire logic [TID_BITS-1:0]  right_thr,
  output logic                      valid,
  output logic [WAKE_BITS-1:0]      wt,
  output logic [TID_BITS-1:0]       thr,
  output logic                      le
);

  // entry is held and due at or before the key
  assign le = valid && (wt <= cmd.key_wt);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_INSERT: begin
        if (!le) begin
          if (left_le) begin
            wt  <= cmd.key_wt;
            thr <= key_thr;
          end else begin
            wt  <= left_wt;
            thr <= left_thr;
          end
        end
      end
      CMD_POP: begin
        wt  <= right_wt;
        thr <= right_thr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (cmd.op)
        CMD_INSERT: begin
          if (!le) begin
            valid <= left_le ? 1'b1 : left_valid;
          end
        end
        CMD_POP: begin
          valid <= right_valid;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_wakeup_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_wakeup_timer_queue
// Tick counter with a wake-time sorted sleep queue held in a chain of cells.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A sleep request goes through accept,
// saturating add of tick count and duration, then one broadcast compare in
// which every cell decides to hold, take the new entry or shift right; its
// single result leaves in the last of these. A tick is accepted and advances
// the count, then while the output does not stall pops one woken entry per
// cycle from the head cell while the chain shifts left, at most sixteen; a
// tick with nothing due ends with no report. A stalled output holds insert
// and pop. Equal wake times keep arrival order; a full queue refuses the sleep.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_wakeup_timer_queue
  import swtq_pkg::*;
#(
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     opcode,
  input  wire logic [TID_PORT_BITS-1:0] thread_id,
  input  wire logic [DUR_BITS-1:0]      sleep_duration,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    kind,
  output logic [TID_PORT_BITS-1:0]      woken_thread,
  output logic [WAKE_BITS-1:0]          wake_time,
  output logic                          last
);

  localparam int TB = THREAD_ID_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_INS  = 2'd2;
  localparam logic [1:0] ST_SCAN = 2'd3;

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [WAKE_BITS-1:0]   tick_count;
  logic [WAKE_BITS-1:0]   req_wt;
  logic [DUR_BITS-1:0]    req_dur;
  logic [TB-1:0]          req_thr;
  logic [REPORT_BITS-1:0] n_reports;

  logic [TB+TID_PORT_BITS-1:0] tid_in_ext;
  logic [TB+TID_PORT_BITS-1:0] tid_out_ext;
  logic [WAKE_BITS:0]          wt_sum;

  logic                 c_valid [QUEUE_DEPTH];
  logic [WAKE_BITS-1:0] c_wt    [QUEUE_DEPTH];
  logic [TB-1:0]        c_thr   [QUEUE_DEPTH];
  logic                 c_le    [QUEUE_DEPTH];

  cell_cmd_t cmd;
  logic      accept;
  logic      out_free;
  logic      emit;
  logic      emit_last;
  logic [1:0] emit_kind;
  logic [WAKE_BITS-1:0] emit_wt;
  logic [TB-1:0]        emit_thr;
  logic      full;

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign full       = c_valid[QUEUE_DEPTH-1];
  assign tid_in_ext = {{TB{1'b0}}, thread_id};
  assign wt_sum     = {1'b0, tick_count} + {{(WAKE_BITS + 1 - DUR_BITS){1'b0}}, req_dur};

  always_comb begin
    state_next = state;
    cmd.op     = CMD_HOLD;
    cmd.key_wt = (state == ST_SCAN) ? tick_count : req_wt;
    emit       = 1'b0;
    emit_last  = 1'b1;
    emit_kind  = KIND_ACCEPTED;
    emit_wt    = req_wt;
    emit_thr   = req_thr;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (opcode == OP_SLEEP) ? ST_ADD : ST_SCAN;
        end
      end
      ST_ADD: begin
        state_next = ST_INS;
      end
      ST_INS: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = full ? KIND_REFUSED : KIND_ACCEPTED;
          cmd.op     = full ? CMD_HOLD : CMD_INSERT;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!c_le[0]) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          emit      = 1'b1;
          emit_kind = KIND_WOKEN;
          emit_wt   = c_wt[0];
          emit_thr  = c_thr[0];
          emit_last = !c_le[1] || (n_reports == REPORT_BITS'(MAX_REPORTS - 1));
          cmd.op    = CMD_POP;
          if (emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      n_reports  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        n_reports <= '0;
        if (opcode == OP_TICK) begin
          tick_count <= tick_count + WAKE_BITS'(1);
        end
      end else if (emit && state == ST_SCAN) begin
        n_reports <= n_reports + REPORT_BITS'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_dur <= sleep_duration;
      req_thr <= tid_in_ext[TB-1:0];
    end
    if (state == ST_ADD) begin
      req_wt <= wt_sum[WAKE_BITS] ? {WAKE_BITS{1'b1}} : wt_sum[WAKE_BITS-1:0];
    end
    if (emit) begin
      kind      <= emit_kind;
      wake_time <= emit_wt;
      last      <= emit_last;
      woken_thread <= tid_out_ext[TID_PORT_BITS-1:0];
    end
  end

  assign tid_out_ext = {{TID_PORT_BITS{1'b0}}, emit_thr};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 lv;
    logic [WAKE_BITS-1:0] lw;
    logic [TB-1:0]        lt;
    logic                 ll;
    logic                 rv;
    logic [WAKE_BITS-1:0] rw;
    logic [TB-1:0]        rt;

    if (i == 0) begin : g_first
      assign lv = 1'b0;
      assign lw = '0;
      assign lt = '0;
      assign ll = 1'b1;
    end else begin : g_mid_l
      assign lv = c_valid[i-1];
      assign lw = c_wt[i-1];
      assign lt = c_thr[i-1];
      assign ll = c_le[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign rv = 1'b0;
      assign rw = '0;
      assign rt = '0;
    end else begin : g_mid_r
      assign rv = c_valid[i+1];
      assign rw = c_wt[i+1];
      assign rt = c_thr[i+1];
    end

    swtq_cell #(
      .TID_BITS(TB)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .key_thr    (req_thr),
      .left_valid (lv),
      .left_wt    (lw),
      .left_thr   (lt),
      .left_le    (ll),
      .right_valid(rv),
      .right_wt   (rw),
      .right_thr  (rt),
      .valid      (c_valid[i]),
      .wt         (c_wt[i]),
      .thr        (c_thr[i]),
      .le         (c_le[i])
    );
  end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench of the sorted wakeup timer queue. A queue of timer commands
// (ticks and sleep requests) feeds a clocked driver; a clocked monitor
// compares every report with a software copy of the sleep queue. Directed
// items cover the empty tick, the zero-length sleep, a full queue with equal
// wake times, a refusal, a sixteen-entry wakeup and the longest duration.
// Random items follow, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import swtq_pkg::*;

  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  localparam logic [TID_PORT_BITS-1:0] TID_MASK =
    TID_PORT_BITS'((1 << THREAD_ID_BITS_DEF) - 1);
  localparam int RANDOM_ITEMS = 200;

  typedef struct packed {
    logic                     op;
    logic [TID_PORT_BITS-1:0] tid;
    logic [DUR_BITS-1:0]      dur;
  } timer_cmd_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [TID_PORT_BITS-1:0] thread;
    logic [WAKE_BITS-1:0]     wake;
    logic                     last;
  } wake_report_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     opcode = OP_TICK;
  logic [TID_PORT_BITS-1:0] thread_id = '0;
  logic [DUR_BITS-1:0]      sleep_duration = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               kind;
  logic [TID_PORT_BITS-1:0] woken_thread;
  logic [WAKE_BITS-1:0]     wake_time;
  logic                     last;

  timer_cmd_t   pending_cmds[$];
  wake_report_t due_reports[$];
  timer_cmd_t   next_cmd;
  wake_report_t want;
  wake_report_t seen;

  // software copy of the block's state
  logic [WAKE_BITS-1:0]     now_tick = '0;
  logic [WAKE_BITS-1:0]     slot_wake[QDEPTH];
  logic [TID_PORT_BITS-1:0] slot_thread[QDEPTH];
  int                       held = 0;

  int  total_cmds = 0;
  int  accepted_cnt = 0;
  int  errors = 0;
  logic steady;

  assign steady = (accepted_cnt >= 110) && (accepted_cnt < 160);

  sorted_wakeup_timer_queue DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .thread_id      (thread_id),
    .sleep_duration (sleep_duration),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .woken_thread   (woken_thread),
    .wake_time      (wake_time),
    .last           (last)
  );

  always #2 clk = ~clk;

  task automatic predict_wakeups(input logic op, input logic [TID_PORT_BITS-1:0] tid_in,
                                 input logic [DUR_BITS-1:0] dur);
    logic [WAKE_BITS:0]       sum;
    logic [WAKE_BITS-1:0]     wt;
    logic [TID_PORT_BITS-1:0] tid;
    int                       pos;
    int                       n;
    int                       i;
    logic                     fin;
    tid = tid_in & TID_MASK;
    if (op == OP_SLEEP) begin
      sum = {1'b0, now_tick} + {{(WAKE_BITS + 1 - DUR_BITS){1'b0}}, dur};
      wt = sum[WAKE_BITS] ? {WAKE_BITS{1'b1}} : sum[WAKE_BITS-1:0];
      if (held >= QDEPTH) begin
        due_reports.push_back('{KIND_REFUSED, tid, wt, 1'b1});
      end else begin
        pos = 0;
        while (pos < held && slot_wake[pos] <= wt) pos++;
        for (i = held; i > pos; i--) begin
          slot_wake[i] = slot_wake[i-1];
          slot_thread[i] = slot_thread[i-1];
        end
        slot_wake[pos] = wt;
        slot_thread[pos] = tid;
        held++;
        due_reports.push_back('{KIND_ACCEPTED, tid, wt, 1'b1});
      end
    end else begin
      now_tick = now_tick + 1'b1;
      n = 0;
      while (n < held && n < MAX_REPORTS && slot_wake[n] <= now_tick) begin
        fin = !((n + 1 < held) && (n + 1 < MAX_REPORTS) && (slot_wake[n+1] <= now_tick));
        due_reports.push_back('{KIND_WOKEN, slot_thread[n], slot_wake[n], fin});
        n++;
      end
      for (i = n; i < held; i++) begin
        slot_wake[i-n] = slot_wake[i];
        slot_thread[i-n] = slot_thread[i];
      end
      held -= n;
    end
  endtask

  task automatic push_cmd(input logic op, input logic [TID_PORT_BITS-1:0] tid,
                          input logic [DUR_BITS-1:0] dur);
    pending_cmds.push_back('{op, tid, dur});
    total_cmds++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_wakeups(opcode, thread_id, sleep_duration);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() != 0 && (steady || $urandom_range(99) >= 32)) begin
          next_cmd = pending_cmds.pop_front();
          opcode <= next_cmd.op;
          thread_id <= next_cmd.tid;
          sleep_duration <= next_cmd.dur;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{kind, woken_thread, wake_time, last};
        if (due_reports.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected item: kind %0d thread %0d wake %0d last %0b",
                     seen.kind, seen.thread, seen.wake, seen.last);
        end else begin
          want = due_reports.pop_front();
          if (seen !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                       want.kind, want.thread, want.wake, want.last,
                       seen.kind, seen.thread, seen.wake, seen.last);
          end
        end
      end
      out_stall <= !steady && ($urandom_range(99) < 32);
    end
  end

  initial begin
    int k;
    int sleep_pct;
    logic [DUR_BITS-1:0] dur;

    // nothing due, then a zero-length sleep woken by the next tick
    push_cmd(OP_TICK, 8'd0, 32'd0);
    push_cmd(OP_SLEEP, 8'd0, 32'd0);
    push_cmd(OP_TICK, 8'hff, 32'hffff_ffff);
    // fill the queue with equal wake times, then one refusal
    for (k = 0; k < QDEPTH; k++) push_cmd(OP_SLEEP, TID_PORT_BITS'(k * 17), 32'd2);
    push_cmd(OP_SLEEP, 8'h5a, 32'd7);
    push_cmd(OP_TICK, 8'h00, 32'h0);
    push_cmd(OP_TICK, 8'haa, 32'h5555_5555);
    push_cmd(OP_SLEEP, 8'hff, 32'hffff_ffff);

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      sleep_pct = ((k / 40) % 2 == 0) ? 75 : 35;
      if ($urandom_range(99) < sleep_pct) begin
        case ($urandom_range(99)) inside
          [0:2]:   dur = $urandom();
          [3:12]:  dur = $urandom_range(60);
          default: dur = $urandom_range(12);
        endcase
        push_cmd(OP_SLEEP, TID_PORT_BITS'($urandom_range(255)), dur);
      end else begin
        push_cmd(OP_TICK, TID_PORT_BITS'($urandom()), $urandom());
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (accepted_cnt != total_cmds) @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
